>>> sv/line_gradient_focus_metric_core_macros.svh
// Assertion macros for the line gradient focus metric core.
// Included by the top level; depends on nothing else.
`ifndef LINE_GRADIENT_FOCUS_METRIC_CORE_MACROS_SVH
`define LINE_GRADIENT_FOCUS_METRIC_CORE_MACROS_SVH

// same-cycle implication
`define LGFM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LGFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lgfm_pkg.sv
// Shared types and constants of the line gradient focus metric core.
// No dependencies; used by lgfm_ctrl, lgfm_dpath and the top level.
package lgfm_pkg;

   localparam int unsigned SAMPLE_W   = 8;
   localparam int unsigned LEN_W      = 11;
   localparam int unsigned IDX_W      = 11;
   localparam int unsigned ACC_W      = 28;
   localparam int unsigned FRAC_W     = 8;
   localparam int unsigned QUO_W      = ACC_W + FRAC_W;
   localparam int unsigned OUT_W      = 34;
   localparam int unsigned WPROD_W    = SAMPLE_W + LEN_W;
   localparam int unsigned CNT_W      = 6;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 11;
   localparam int unsigned SEL_W      = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNEL = 2'd0,
      CSR_METHOD  = 2'd1,
      CSR_TENT    = 2'd2,
      CSR_LENGTH  = 2'd3
   } csr_index_type;

   localparam logic [SEL_W-1:0] CH_RED        = 2'd0;
   localparam logic [SEL_W-1:0] CH_GREEN      = 2'd1;
   localparam logic [SEL_W-1:0] CH_BLUE       = 2'd2;
   localparam logic [SEL_W-1:0] METHOD_SUM    = 2'd0;
   localparam logic [SEL_W-1:0] METHOD_CENTRE = 2'd1;

   typedef enum logic [1:0] {
      ST_ACCUM  = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

   typedef struct packed {
      logic take_pixel;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_pixel;
      logic div_busy;
   } sts_type;

endpackage

>>> sv/line_gradient_focus_metric_core.sv
// Line gradient focus metric core: top level joining lgfm_ctrl and lgfm_dpath.
// Pixels inside a line are taken back to back while req_stall is low. With tent
// weighting the result of a line also passes the 36-step restoring divider.
// Input is held off from the last pixel until the result enters the output register.
// Reset is synchronous active high; it restores register defaults and clears the line.
// Depends on lgfm_pkg and line_gradient_focus_metric_core_macros.svh.
`include "line_gradient_focus_metric_core_macros.svh"

module line_gradient_focus_metric_core #(
   parameter int unsigned MAX_LINE_LENGTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lgfm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lgfm_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lgfm_pkg::SAMPLE_W-1:0]      req_red_sample,
   input  logic [lgfm_pkg::SAMPLE_W-1:0]      req_green_sample,
   input  logic [lgfm_pkg::SAMPLE_W-1:0]      req_blue_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lgfm_pkg::OUT_W-1:0]         rsp_focus_value
);

   lgfm_pkg::cmd_type cmd;
   lgfm_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   lgfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lgfm_dpath #(
      .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .red_sample   (req_red_sample),
      .green_sample (req_green_sample),
      .blue_sample  (req_blue_sample),
      .cmd          (cmd),
      .sts          (sts),
      .focus_value  (rsp_focus_value)
   );

   `LGFM_ASSERT_NOW(a_no_input_while_dividing, clock, reset, sts.div_busy, req_stall, "pixel accepted during divide")
   `LGFM_ASSERT_NOW(a_no_result_overwrite, clock, reset, cmd.out_load, (!rsp_valid || !rsp_stall), "pending result overwritten")
   `LGFM_ASSERT_NEXT(a_load_shows_result, clock, reset, cmd.out_load, rsp_valid, "loaded result not presented")

endmodule

>>> sv/lgfm_ctrl.sv
// Controller of the line gradient focus metric core: line, divide and finish sequencing.
// Depends on lgfm_pkg; drives commands to lgfm_dpath and owns the handshakes.
module lgfm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  lgfm_pkg::sts_type  sts,
   output lgfm_pkg::cmd_type  cmd
);

   lgfm_pkg::state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic out_take;

   assign rsp_valid = out_valid_ff;
   assign out_take  = out_valid_ff & ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lgfm_pkg::ST_ACCUM: begin
            if (req_valid && sts.last_pixel) state_in = lgfm_pkg::ST_DIVIDE;
         end
         lgfm_pkg::ST_DIVIDE: begin
            if (!sts.div_busy) state_in = lgfm_pkg::ST_FINISH;
         end
         lgfm_pkg::ST_FINISH: begin
            if (!out_valid_ff || out_take) state_in = lgfm_pkg::ST_ACCUM;
         end
         default: state_in = lgfm_pkg::ST_ACCUM;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      cmd       = '0;
      unique case (state_ff)
         lgfm_pkg::ST_ACCUM: begin
            req_stall      = 1'b0;
            cmd.take_pixel = req_valid;
         end
         lgfm_pkg::ST_DIVIDE: begin
            cmd.div_step = sts.div_busy;
         end
         lgfm_pkg::ST_FINISH: begin
            cmd.out_load = ~out_valid_ff | out_take;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign out_valid_in = cmd.out_load | (out_valid_ff & ~out_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgfm_pkg::ST_ACCUM;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> sv/lgfm_dpath.sv
// Datapath of the line gradient focus metric core: registers, gradient accumulator,
// restoring divider and centre-sample product. Depends on lgfm_pkg.
module lgfm_dpath #(
   parameter int unsigned MAX_LINE_LENGTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [lgfm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lgfm_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [lgfm_pkg::SAMPLE_W-1:0]       red_sample,
   input  logic [lgfm_pkg::SAMPLE_W-1:0]       green_sample,
   input  logic [lgfm_pkg::SAMPLE_W-1:0]       blue_sample,
   input  lgfm_pkg::cmd_type                   cmd,
   output lgfm_pkg::sts_type                   sts,
   output logic [lgfm_pkg::OUT_W-1:0]          focus_value
);

   localparam int unsigned SW = lgfm_pkg::SAMPLE_W;
   localparam int unsigned LW = lgfm_pkg::LEN_W;
   localparam int unsigned IW = lgfm_pkg::IDX_W;
   localparam int unsigned AW = lgfm_pkg::ACC_W;
   localparam int unsigned QW = lgfm_pkg::QUO_W;
   localparam int unsigned OW = lgfm_pkg::OUT_W;
   localparam int unsigned PW = lgfm_pkg::WPROD_W;
   localparam int unsigned CW = lgfm_pkg::CNT_W;
   localparam int unsigned LEN_FULL = (1 << LW) - 1;
   localparam int unsigned LEN_CAP_INT =
      (MAX_LINE_LENGTH > LEN_FULL) ? LEN_FULL : MAX_LINE_LENGTH;
   localparam logic [LW-1:0] LEN_CAP = LEN_CAP_INT[LW-1:0];
   localparam logic [LW-1:0] LEN_DEFAULT = LEN_CAP_INT[LW-1:0];
   localparam logic [CW-1:0] DIV_STEPS = QW[CW-1:0];

   // configuration
   logic [lgfm_pkg::SEL_W-1:0] channel_ff, channel_in;
   logic [lgfm_pkg::SEL_W-1:0] method_ff, method_in;
   logic                       tent_ff, tent_in;
   logic [LW-1:0]              length_ff, length_in;

   // line state
   logic [SW-1:0] prev_ff, prev_in;
   logic [IW-1:0] index_ff, index_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [SW-1:0] centre_ff, centre_in;

   // finish state
   logic [QW-1:0] quo_ff, quo_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [LW-1:0] div_len_ff, div_len_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ok_ff, ok_in;
   logic          mul_ff, mul_in;
   logic [SW-1:0] fin_centre_ff, fin_centre_in;
   logic [OW-1:0] out_ff, out_in;

   logic [LW-1:0]     eff_len;
   logic [SW-1:0]     sample;
   logic [SW-1:0]     diff;
   logic [LW:0]       len_x;
   logic [LW:0]       tent_pos;
   logic [LW:0]       tent_dist;
   logic [LW:0]       tent_rest;
   logic [LW-1:0]     tent_num;
   logic [PW-1:0]     wprod;
   logic [PW-1:0]     wdiff;
   logic [AW:0]       acc_sum;
   logic [AW-1:0]     acc_next;
   logic              is_centre;
   logic [SW-1:0]     centre_next;
   logic              last_pixel;
   logic [LW:0]       rem_shift;
   logic [LW:0]       rem_diff;
   logic              rem_fits;
   logic [OW+SW-1:0]  product;

   always_comb begin
      if (length_ff == '0) eff_len = {{(LW-1){1'b0}}, 1'b1};
      else if (length_ff > LEN_CAP) eff_len = LEN_CAP;
      else eff_len = length_ff;
   end

   always_comb begin
      case (channel_ff)
         lgfm_pkg::CH_RED:   sample = red_sample;
         lgfm_pkg::CH_GREEN: sample = green_sample;
         lgfm_pkg::CH_BLUE:  sample = blue_sample;
         default:            sample = '0;
      endcase
   end

   always_comb begin
      diff      = (sample > prev_ff) ? (sample - prev_ff) : (prev_ff - sample);
      len_x     = {1'b0, eff_len};
      tent_pos  = {index_ff, 1'b0} - {{LW{1'b0}}, 1'b1};
      tent_dist = (tent_pos > len_x) ? (tent_pos - len_x) : (len_x - tent_pos);
      tent_rest = len_x - tent_dist;
      tent_num  = (tent_dist >= len_x) ? '0 : tent_rest[LW-1:0];
      wprod     = diff * tent_num;
      wdiff     = tent_ff ? wprod : {{(PW-SW){1'b0}}, diff};
      acc_sum   = {1'b0, acc_ff} + {{(AW+1-PW){1'b0}}, wdiff};
      if (index_ff == '0) acc_next = acc_ff;
      else if (acc_sum[AW]) acc_next = '1;
      else acc_next = acc_sum[AW-1:0];
      is_centre   = (index_ff == (eff_len >> 1));
      centre_next = is_centre ? sample : centre_ff;
      last_pixel  = ({1'b0, index_ff} + {{IW{1'b0}}, 1'b1}) >= len_x;
   end

   assign sts.last_pixel = last_pixel;
   assign sts.div_busy   = (cnt_ff != '0);

   always_comb begin
      rem_shift = {rem_ff, quo_ff[QW-1]};
      rem_fits  = rem_shift >= {1'b0, div_len_ff};
      rem_diff  = rem_shift - {1'b0, div_len_ff};
      product   = quo_ff[OW-1:0] * fin_centre_ff;
   end

   always_comb begin
      channel_in = channel_ff;
      method_in  = method_ff;
      tent_in    = tent_ff;
      length_in  = length_ff;
      if (csr_valid) begin
         unique case (lgfm_pkg::csr_index_type'(csr_index))
            lgfm_pkg::CSR_CHANNEL: channel_in = csr_data[lgfm_pkg::SEL_W-1:0];
            lgfm_pkg::CSR_METHOD:  method_in  = csr_data[lgfm_pkg::SEL_W-1:0];
            lgfm_pkg::CSR_TENT:    tent_in    = csr_data[0];
            lgfm_pkg::CSR_LENGTH:  length_in  = csr_data[LW-1:0];
            default:               channel_in = channel_ff;
         endcase
      end
   end

   always_comb begin
      prev_in       = prev_ff;
      index_in      = index_ff;
      acc_in        = acc_ff;
      centre_in     = centre_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_len_in    = div_len_ff;
      cnt_in        = cnt_ff;
      ok_in         = ok_ff;
      mul_in        = mul_ff;
      fin_centre_in = fin_centre_ff;
      out_in        = out_ff;
      if (cmd.take_pixel) begin
         prev_in   = sample;
         centre_in = centre_next;
         if (last_pixel) begin
            index_in      = '0;
            acc_in        = '0;
            quo_in        = {acc_next, {lgfm_pkg::FRAC_W{1'b0}}};
            rem_in        = '0;
            div_len_in    = eff_len;
            cnt_in        = tent_ff ? DIV_STEPS : '0;
            ok_in         = (channel_ff <= lgfm_pkg::CH_BLUE) &&
                            (method_ff <= lgfm_pkg::METHOD_CENTRE);
            mul_in        = (method_ff == lgfm_pkg::METHOD_CENTRE);
            fin_centre_in = centre_next;
         end else begin
            index_in = index_ff + {{(IW-1){1'b0}}, 1'b1};
            acc_in   = acc_next;
         end
      end
      if (cmd.div_step) begin
         cnt_in = cnt_ff - {{(CW-1){1'b0}}, 1'b1};
         quo_in = {quo_ff[QW-2:0], rem_fits};
         rem_in = rem_fits ? rem_diff[LW-1:0] : rem_shift[LW-1:0];
      end
      if (cmd.out_load) begin
         if (!ok_ff) out_in = '0;
         else if (mul_ff) out_in = product[OW-1:0];
         else out_in = quo_ff[OW-1:0];
      end
   end

   assign focus_value = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= lgfm_pkg::CH_RED;
         method_ff  <= lgfm_pkg::METHOD_SUM;
         tent_ff    <= 1'b0;
         length_ff  <= LEN_DEFAULT;
         prev_ff    <= '0;
         index_ff   <= '0;
         acc_ff     <= '0;
         centre_ff  <= '0;
         cnt_ff     <= '0;
      end else begin
         channel_ff <= channel_in;
         method_ff  <= method_in;
         tent_ff    <= tent_in;
         length_ff  <= length_in;
         prev_ff    <= prev_in;
         index_ff   <= index_in;
         acc_ff     <= acc_in;
         centre_ff  <= centre_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      div_len_ff    <= div_len_in;
      ok_ff         <= ok_in;
      mul_ff        <= mul_in;
      fin_centre_ff <= fin_centre_in;
      out_ff        <= out_in;
   end

endmodule

>>> tb/sv/tb_line_gradient_focus_metric_core.sv
// Self-checking testbench for line_gradient_focus_metric_core: drives pixel lines,
// rewrites the control registers between phases and checks each focus value.
// Depends on lgfm_pkg and the RTL of the core; reads no files.
`timescale 1ns / 1ps

module tb_line_gradient_focus_metric_core;

   localparam int unsigned LINE_MAX      = 1024;
   localparam int unsigned DRAIN_CYCLES  = 48;
   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned RANDOM_PIXELS = 900;
   localparam longint unsigned SUM_MAX   = (64'd1 << lgfm_pkg::ACC_W) - 64'd1;

   localparam logic [lgfm_pkg::SEL_W-1:0] CH_INVALID        = 2'd3;
   localparam logic [lgfm_pkg::SEL_W-1:0] METHOD_INVALID_LO = 2'd2;
   localparam logic [lgfm_pkg::SEL_W-1:0] METHOD_INVALID_HI = 2'd3;

   typedef struct packed {
      logic [lgfm_pkg::SAMPLE_W-1:0] red;
      logic [lgfm_pkg::SAMPLE_W-1:0] green;
      logic [lgfm_pkg::SAMPLE_W-1:0] blue;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [lgfm_pkg::CSR_IDX_W-1:0] csr_index = lgfm_pkg::CSR_CHANNEL;
   logic [lgfm_pkg::CSR_DATA_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [lgfm_pkg::SAMPLE_W-1:0] req_red_sample = '0;
   logic [lgfm_pkg::SAMPLE_W-1:0] req_green_sample = '0;
   logic [lgfm_pkg::SAMPLE_W-1:0] req_blue_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [lgfm_pkg::OUT_W-1:0] rsp_focus_value;

   line_gradient_focus_metric_core #(
      .MAX_LINE_LENGTH(LINE_MAX)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_red_sample(req_red_sample),
      .req_green_sample(req_green_sample),
      .req_blue_sample(req_blue_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_focus_value(rsp_focus_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of registers and line state
   logic [lgfm_pkg::SEL_W-1:0] cfg_channel = lgfm_pkg::CH_RED;
   logic [lgfm_pkg::SEL_W-1:0] cfg_method = lgfm_pkg::METHOD_SUM;
   logic cfg_tent = 1'b0;
   logic [lgfm_pkg::LEN_W-1:0] cfg_length = 11'd1024;
   logic [lgfm_pkg::SAMPLE_W-1:0] prev_sample = '0;
   logic [lgfm_pkg::SAMPLE_W-1:0] centre_px = '0;
   int unsigned line_pos = 0;
   longint unsigned grad_sum = 0;

   pixel_type pixel_pending[$];
   logic [lgfm_pkg::OUT_W-1:0] focus_expected[$];
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned error_count = 0;
   int unsigned pixels_taken = 0;
   int unsigned lines_predicted = 0;
   int unsigned values_checked = 0;
   int unsigned csr_writes = 0;
   int unsigned cycle_count = 0;

   task automatic accumulate_gradient(input pixel_type px);
      longint unsigned len;
      longint unsigned diff;
      longint unsigned tpos;
      longint unsigned span;
      longint unsigned focus;
      logic [lgfm_pkg::SAMPLE_W-1:0] smp;
      len = (cfg_length == 0) ? 1 : ((cfg_length > LINE_MAX) ? LINE_MAX : cfg_length);
      case (cfg_channel)
         lgfm_pkg::CH_RED: smp = px.red;
         lgfm_pkg::CH_GREEN: smp = px.green;
         lgfm_pkg::CH_BLUE: smp = px.blue;
         default: smp = '0;
      endcase
      if (line_pos > 0) begin
         diff = (smp > prev_sample) ? longint'(smp - prev_sample) : longint'(prev_sample - smp);
         if (cfg_tent) begin
            tpos = 2 * (longint'(line_pos) - 1) + 1;
            span = (tpos > len) ? tpos - len : len - tpos;
            diff = diff * ((span >= len) ? 0 : len - span);
         end
         grad_sum = grad_sum + diff;
         if (grad_sum > SUM_MAX)
            grad_sum = SUM_MAX;
      end
      if (line_pos == len / 2)
         centre_px = smp;
      prev_sample = smp;
      if (line_pos + 1 >= len) begin
         focus = 0;
         if (cfg_channel <= lgfm_pkg::CH_BLUE && cfg_method <= lgfm_pkg::METHOD_CENTRE) begin
            focus = grad_sum << lgfm_pkg::FRAC_W;
            if (cfg_tent)
               focus = focus / len;
            if (cfg_method == lgfm_pkg::METHOD_CENTRE)
               focus = focus * centre_px;
         end
         focus_expected.push_back(focus[lgfm_pkg::OUT_W-1:0]);
         lines_predicted++;
         line_pos = 0;
         grad_sum = 0;
      end else begin
         line_pos++;
      end
   endtask

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            accumulate_gradient({req_red_sample, req_green_sample, req_blue_sample});
            pixels_taken++;
         end
         if (pixel_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_red_sample <= pixel_pending[0].red;
            req_green_sample <= pixel_pending[0].green;
            req_blue_sample <= pixel_pending[0].blue;
            pixel_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (focus_expected.size() == 0) begin
            $error("focus_value %0d arrived with no result expected", rsp_focus_value);
            error_count++;
         end else begin
            if (rsp_focus_value !== focus_expected[0]) begin
               $error("focus_value mismatch: expected %0d, actual %0d",
                      focus_expected[0], rsp_focus_value);
               error_count++;
            end
            values_checked++;
            focus_expected.pop_front();
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic settle_block();
      while (pixel_pending.size() != 0 || req_valid || focus_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input lgfm_pkg::csr_index_type idx,
                                 input logic [lgfm_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lgfm_pkg::CSR_CHANNEL: cfg_channel = value[lgfm_pkg::SEL_W-1:0];
         lgfm_pkg::CSR_METHOD: cfg_method = value[lgfm_pkg::SEL_W-1:0];
         lgfm_pkg::CSR_TENT: cfg_tent = value[0];
         lgfm_pkg::CSR_LENGTH: cfg_length = value[lgfm_pkg::LEN_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic program_block(input logic [lgfm_pkg::SEL_W-1:0] ch,
                                input logic [lgfm_pkg::SEL_W-1:0] meth,
                                input logic tent, input logic [lgfm_pkg::LEN_W-1:0] len);
      settle_block();
      write_register(lgfm_pkg::CSR_CHANNEL, lgfm_pkg::CSR_DATA_W'(ch));
      write_register(lgfm_pkg::CSR_METHOD, lgfm_pkg::CSR_DATA_W'(meth));
      write_register(lgfm_pkg::CSR_TENT, lgfm_pkg::CSR_DATA_W'(tent));
      write_register(lgfm_pkg::CSR_LENGTH, len);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [lgfm_pkg::SAMPLE_W-1:0] random_level();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return lgfm_pkg::SAMPLE_W'($urandom_range(255));
   endfunction

   function automatic void queue_pixel(input logic [lgfm_pkg::SAMPLE_W-1:0] r,
                                       input logic [lgfm_pkg::SAMPLE_W-1:0] g,
                                       input logic [lgfm_pkg::SAMPLE_W-1:0] b);
      pixel_type px;
      px.red = r;
      px.green = g;
      px.blue = b;
      pixel_pending.push_back(px);
   endfunction

   function automatic int unsigned pixels_per_line(input logic [lgfm_pkg::LEN_W-1:0] len);
      return (len == 0) ? 1 : ((len > LINE_MAX) ? LINE_MAX : len);
   endfunction

   function automatic void set_idling(input int unsigned phase);
      case (phase % 4)
         0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
         1: begin sender_idle_pct = 73; receiver_stall_pct = 0; end
         2: begin sender_idle_pct = 0; receiver_stall_pct = 73; end
         default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
      endcase
   endfunction

   initial begin
      int unsigned random_count;
      int unsigned phase;
      int unsigned lines;
      int unsigned count;
      int unsigned pick;
      logic [lgfm_pkg::SEL_W-1:0] ch;
      logic [lgfm_pkg::SEL_W-1:0] meth;
      logic [lgfm_pkg::LEN_W-1:0] len;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      program_block(lgfm_pkg::CH_RED, lgfm_pkg::METHOD_SUM, 1'b0, 11'd1);
      queue_pixel(8'd200, 8'd1, 8'd2);
      program_block(lgfm_pkg::CH_RED, lgfm_pkg::METHOD_SUM, 1'b0, 11'd0);
      queue_pixel(8'd255, 8'd255, 8'd255);
      program_block(lgfm_pkg::CH_RED, lgfm_pkg::METHOD_SUM, 1'b0, 11'd4);
      queue_pixel(8'd0, 8'd255, 8'd0);
      queue_pixel(8'd255, 8'd0, 8'd255);
      queue_pixel(8'd0, 8'd255, 8'd0);
      queue_pixel(8'd255, 8'd0, 8'd255);
      program_block(lgfm_pkg::CH_GREEN, lgfm_pkg::METHOD_CENTRE, 1'b1, 11'd5);
      queue_pixel(8'd0, 8'd255, 8'd9);
      queue_pixel(8'd255, 8'd0, 8'd9);
      queue_pixel(8'd0, 8'd255, 8'd9);
      queue_pixel(8'd255, 8'd0, 8'd9);
      queue_pixel(8'd0, 8'd255, 8'd9);
      program_block(lgfm_pkg::CH_BLUE, lgfm_pkg::METHOD_SUM, 1'b1, 11'd3);
      queue_pixel(8'd5, 8'd6, 8'd17);
      queue_pixel(8'd5, 8'd6, 8'd200);
      queue_pixel(8'd5, 8'd6, 8'd3);
      program_block(CH_INVALID, lgfm_pkg::METHOD_SUM, 1'b0, 11'd2);
      queue_pixel(8'd0, 8'd0, 8'd0);
      queue_pixel(8'd255, 8'd255, 8'd255);
      program_block(lgfm_pkg::CH_RED, METHOD_INVALID_LO, 1'b0, 11'd2);
      queue_pixel(8'd0, 8'd1, 8'd2);
      queue_pixel(8'd255, 8'd1, 8'd2);
      program_block(lgfm_pkg::CH_RED, METHOD_INVALID_HI, 1'b1, 11'd2);
      queue_pixel(8'd0, 8'd1, 8'd2);
      queue_pixel(8'd255, 8'd1, 8'd2);
      // shorten the line under a partly received one
      program_block(lgfm_pkg::CH_RED, lgfm_pkg::METHOD_SUM, 1'b1, 11'd6);
      queue_pixel(8'd10, 8'd0, 8'd0);
      queue_pixel(8'd250, 8'd0, 8'd0);
      queue_pixel(8'd30, 8'd0, 8'd0);
      queue_pixel(8'd90, 8'd0, 8'd0);
      program_block(lgfm_pkg::CH_RED, lgfm_pkg::METHOD_SUM, 1'b1, 11'd2);
      queue_pixel(8'd255, 8'd0, 8'd0);

      // largest output: full line of full-swing steps, scaled by the centre
      set_idling(0);
      program_block(lgfm_pkg::CH_RED, lgfm_pkg::METHOD_CENTRE, 1'b0, 11'd1024);
      for (int i = 0; i < LINE_MAX; i++)
         queue_pixel((i % 2 == 0) ? 8'd255 : 8'd0, random_level(), random_level());
      set_idling(3);
      program_block(lgfm_pkg::CH_GREEN, lgfm_pkg::METHOD_CENTRE, 1'b1, 11'd2047);
      for (int i = 0; i < LINE_MAX; i++)
         queue_pixel(random_level(), (i % 2 == 0) ? 8'd0 : 8'd255, random_level());

      random_count = 0;
      phase = 0;
      while (random_count < RANDOM_PIXELS) begin
         set_idling(phase);
         ch = ($urandom_range(9) == 0) ? CH_INVALID :
              lgfm_pkg::SEL_W'($urandom_range(2));
         pick = $urandom_range(9);
         meth = (pick == 0) ? METHOD_INVALID_LO :
                (pick == 1) ? METHOD_INVALID_HI : lgfm_pkg::SEL_W'($urandom_range(1));
         pick = $urandom_range(99);
         if (pick < 5)
            len = 11'd0;
         else if (pick < 10)
            len = 11'd1;
         else if (pick < 80)
            len = lgfm_pkg::LEN_W'($urandom_range(16, 2));
         else if (pick < 96)
            len = lgfm_pkg::LEN_W'($urandom_range(64, 17));
         else
            len = lgfm_pkg::LEN_W'($urandom_range(200, 65));
         program_block(ch, meth, 1'($urandom_range(1)), len);
         lines = $urandom_range(6, 2);
         for (int n = 0; n < lines; n++) begin
            for (int i = 0; i < pixels_per_line(len); i++)
               queue_pixel(random_level(), random_level(), random_level());
            random_count += pixels_per_line(len);
         end
         // leave a partial line for the next setting to finish
         if ($urandom_range(9) == 0) begin
            count = $urandom_range(pixels_per_line(len) - 1);
            for (int i = 0; i < count; i++)
               queue_pixel(random_level(), random_level(), random_level());
            random_count += count;
         end
         phase++;
      end

      settle_block();
      $display("pixels driven %0d, lines predicted %0d, focus values checked %0d",
               pixels_taken, lines_predicted, values_checked);
      $display("register writes %0d over %0d random phases", csr_writes, phase);
      if (error_count == 0 && focus_expected.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
